@@ rtl/hdlc_frame_receiver_destuffer_assert.svh @@
// Assertion macros shared by the HDLC receiver RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef HDLC_FRAME_RECEIVER_DESTUFFER_ASSERT_SVH
`define HDLC_FRAME_RECEIVER_DESTUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HFRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hfrd assertion failed");
// next-cycle implication
`define HFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hfrd assertion failed");
`else
`define HFRD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/hfrd_pkg.sv @@
// Types and constants for the HDLC receiver / destuffer.
// No dependencies.
package hfrd_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_MASK   = 8'h20;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  localparam logic [1:0] KIND_SUPER    = 2'd0;
  localparam logic [1:0] KIND_INFO_OK  = 2'd1;
  localparam logic [1:0] KIND_INFO_BAD = 2'd2;

  typedef enum logic [1:0] {
    TOK_START,
    TOK_DATA,
    TOK_CLOSE
  } tok_kind_t;

  // event passed from the framer to the payload stage
  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] val;
    logic [7:0] ctrl;
  } tok_t;

endpackage

@@ rtl/hfrd_if.sv @@
// Valid/ready channel interfaces: raw bytes in, results out, config write.
// No dependencies.
interface hfrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hfrd_out_if;
  logic       valid;
  logic       ready;
  logic       is_frame_end;
  logic [7:0] payload_byte;
  logic [7:0] control_byte;
  logic [1:0] frame_kind;
  modport source (output valid, output is_frame_end, output payload_byte,
                  output control_byte, output frame_kind, input ready);
  modport sink   (input valid, input is_frame_end, input payload_byte,
                  input control_byte, input frame_kind, output ready);
endinterface

interface hfrd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] address_byte;
  modport source (output valid, output address_byte, input ready);
  modport sink   (input valid, input address_byte, output ready);
endinterface

@@ rtl/hfrd_front.sv @@
// Front end: destuffs raw bytes and tracks flag/address/control/header check.
// Uses hfrd_pkg, hfrd_in_if and the assertion macro header.
`include "hdlc_frame_receiver_destuffer_assert.svh"
module hfrd_front (
  input  logic             clk,
  input  logic             rst_n,
  hfrd_in_if.sink          in_if,
  input  logic [7:0]       address_byte,
  input  logic             q_full,
  output logic             push,
  output hfrd_pkg::tok_t   push_tok
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_DATA
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] val;
  logic       take;
  logic       tok_vld;

  assign in_if.ready = !q_full;
  assign take        = in_if.valid && !q_full;
  assign val         = esc_r ? (in_if.rx_byte ^ hfrd_pkg::ESC_MASK) : in_if.rx_byte;

  always_comb begin
    phase_nxt     = phase_r;
    esc_nxt       = esc_r;
    ctrl_nxt      = ctrl_r;
    tok_vld       = 1'b0;
    push_tok.kind = hfrd_pkg::TOK_DATA;
    push_tok.val  = val;
    push_tok.ctrl = ctrl_r;
    priority if (in_if.rx_byte == hfrd_pkg::FLAG_BYTE) begin
      esc_nxt = 1'b0;
      if (phase_r == PH_DATA) begin
        tok_vld       = 1'b1;
        push_tok.kind = hfrd_pkg::TOK_CLOSE;
        phase_nxt     = PH_HUNT;
      end else begin
        phase_nxt = PH_FLAG;
      end
    end else if (phase_r == PH_HUNT) begin
      esc_nxt = 1'b0;
    end else if (in_if.rx_byte == hfrd_pkg::ESC_BYTE && !esc_r) begin
      esc_nxt = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      unique case (phase_r)
        PH_FLAG: phase_nxt = (val == address_byte) ? PH_ADDR : PH_HUNT;
        PH_ADDR: begin
          ctrl_nxt  = val;
          phase_nxt = PH_CTRL;
        end
        PH_CTRL: begin
          if (val == (address_byte ^ ctrl_r)) begin
            phase_nxt     = PH_DATA;
            tok_vld       = 1'b1;
            push_tok.kind = hfrd_pkg::TOK_START;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: tok_vld = 1'b1;
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  assign push = take && tok_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      esc_r   <= 1'b0;
      ctrl_r  <= 8'h00;
    end else if (take) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  // a pending escape only exists inside a frame
  `HFRD_ASSERT_IMPL(a_esc_in_frame, clk, rst_n, esc_r, phase_r != PH_HUNT)

endmodule

@@ rtl/hfrd_fifo.sv @@
// Small token queue between the framer and the payload stage.
// Uses hfrd_pkg and the assertion macro header.
`include "hdlc_frame_receiver_destuffer_assert.svh"
module hfrd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hfrd_pkg::tok_t push_tok,
  input  logic           pop,
  output hfrd_pkg::tok_t pop_tok,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hfrd_pkg::tok_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign pop_tok = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `HFRD_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full)
  `HFRD_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

@@ rtl/hfrd_back.sv @@
// Back end: one-byte payload delay, payload XOR check, result register.
// Uses hfrd_pkg, hfrd_out_if and the assertion macro header.
`include "hdlc_frame_receiver_destuffer_assert.svh"
module hfrd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  hfrd_pkg::tok_t tok,
  output logic           pop,
  hfrd_out_if.source     out_if
);

  logic       held_valid_r;
  logic [7:0] held_r;
  logic [7:0] xor_r;
  logic       out_valid_r;
  logic       out_end_r;
  logic [7:0] out_pay_r;
  logic [7:0] out_ctrl_r;
  logic [1:0] out_kind_r;
  logic       out_free;
  logic       emit;
  logic [1:0] close_kind;

  assign out_free = !out_valid_r || out_if.ready;
  assign pop      = !q_empty && out_free;
  assign emit     = pop && ((tok.kind == hfrd_pkg::TOK_CLOSE) ||
                            (tok.kind == hfrd_pkg::TOK_DATA && held_valid_r));

  always_comb begin
    if (!held_valid_r)        close_kind = hfrd_pkg::KIND_SUPER;
    else if (xor_r == held_r) close_kind = hfrd_pkg::KIND_INFO_OK;
    else                      close_kind = hfrd_pkg::KIND_INFO_BAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_r       <= 8'h00;
      xor_r        <= 8'h00;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        unique case (tok.kind)
          hfrd_pkg::TOK_START: begin
            held_valid_r <= 1'b0;
            xor_r        <= 8'h00;
          end
          hfrd_pkg::TOK_DATA: begin
            if (held_valid_r) xor_r <= xor_r ^ held_r;
            held_r       <= tok.val;
            held_valid_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (emit)          out_valid_r <= 1'b1;
      else if (out_free) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ctrl_r <= tok.ctrl;
      if (tok.kind == hfrd_pkg::TOK_CLOSE) begin
        out_end_r  <= 1'b1;
        out_pay_r  <= 8'h00;
        out_kind_r <= close_kind;
      end else begin
        out_end_r  <= 1'b0;
        out_pay_r  <= held_r;
        out_kind_r <= hfrd_pkg::KIND_SUPER;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.is_frame_end = out_end_r;
  assign out_if.payload_byte = out_pay_r;
  assign out_if.control_byte = out_ctrl_r;
  assign out_if.frame_kind   = out_kind_r;

  // payload items never carry a frame kind
  `HFRD_ASSERT_IMPL(a_pay_kind, clk, rst_n, out_valid_r && !out_end_r,
                    out_kind_r == hfrd_pkg::KIND_SUPER)
  // a stalled result is never overwritten
  `HFRD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid_r && !out_if.ready,
                    out_valid_r && $stable(out_pay_r) && $stable(out_kind_r))

endmodule

@@ rtl/hdlc_frame_receiver_destuffer.sv @@
// Channel  Dir  Payload                                               Accepted when
// in_if    in   rx_byte[7:0]                                          valid && ready
// out_if   out  is_frame_end, payload_byte, control_byte, frame_kind  valid && ready
// cfg_if   in   address_byte[7:0]                                     valid && ready
//
// One raw byte per cycle unless the queue is full; tokens pass queue, then result register.
// Throughput is set by the token queue: in_if.ready drops only while it is full.
// rst_n is synchronous: framer hunts, queue empties, address returns to 0x03.
// out_if stalls back up through the queue; cfg_if is always ready.
module hdlc_frame_receiver_destuffer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  hfrd_in_if.sink   in_if,
  hfrd_out_if.source out_if,
  hfrd_cfg_if.sink  cfg_if
);

  logic           cfg_wr;
  logic [7:0]     addr_r;
  logic           q_full, q_empty, push, pop;
  hfrd_pkg::tok_t push_tok, pop_tok;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= hfrd_pkg::ADDR_RESET;
    end else if (cfg_wr) begin
      addr_r <= cfg_if.address_byte;
    end
  end

  hfrd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .address_byte (addr_r),
    .q_full       (q_full),
    .push         (push),
    .push_tok     (push_tok)
  );

  hfrd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .empty    (q_empty),
    .full     (q_full)
  );

  hfrd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .tok     (pop_tok),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule
